[hdl/mtrd_pkg.sv]
`timescale 1ns / 1ps
package mtrd_pkg;
	localparam int unsigned TblLen = 624;
	localparam int unsigned TblOfs = 397;
	localparam int unsigned IdxW = 10;
	localparam logic [31:0] TwistXor = 32'h9908b0df;
	localparam logic [31:0] HiBit = 32'h80000000;
	localparam logic [31:0] LoBits = 32'h7fffffff;
	localparam logic [31:0] TemperB = 32'h9d2c5680;
	localparam logic [31:0] TemperC = 32'hefc60000;
	localparam logic [31:0] SeedMul = 32'd69069;

	typedef enum logic {
		REQ_DRAW = 1'b0,
		REQ_SEED = 1'b1
	} req_t;

	// One queued command from the front part to the back part.
	typedef struct packed {
		req_t        kind;
		logic [31:0] seed;
		logic [31:0] range;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_SEED,
		ST_TWIST,
		ST_READ,
		ST_DIV,
		ST_OUT
	} state_t;

	function automatic logic [31:0] mix_word(logic [31:0] up, logic [31:0] lo,
		logic [31:0] far);
		logic [31:0] y;
		logic [31:0] v;
		y = (up & HiBit) | (lo & LoBits);
		v = far ^ (y >> 1);
		if (y[0]) begin
			v = v ^ TwistXor;
		end
		return v;
	endfunction

	function automatic logic [31:0] temper(logic [31:0] w);
		logic [31:0] y;
		y = w ^ (w >> 11);
		y = y ^ ((y << 7) & TemperB);
		y = y ^ ((y << 15) & TemperC);
		y = y ^ (y >> 18);
		return y;
	endfunction
endpackage

[hdl/mtrd_front.sv]
`timescale 1ns / 1ps
module mtrd_front
	import mtrd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [31:0] seed_value,
	input  logic [31:0] range_limit,
	output logic        cmd_valid,
	input  logic        cmd_ready,
	output cmd_t        cmd
);
	// Two-entry queue of classified commands.
	cmd_t        buf_q [2];
	logic        wptr_q;
	logic        rptr_q;
	logic [1:0]  cnt_q;
	logic        push;
	logic        pop;

	assign in_ready = (cnt_q != 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = buf_q[rptr_q];
	assign push = in_valid && in_ready;
	assign pop = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wptr_q] <= '{kind: req_t'(req_type), seed: seed_value, range: range_limit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

[hdl/mtrd_div.sv]
`timescale 1ns / 1ps
module mtrd_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] remainder
);
	// Restoring divider, one quotient bit per cycle.
	logic [31:0] num_q;
	logic [32:0] rem_q;
	logic [31:0] den_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [32:0] trial;
	logic [32:0] shifted;

	assign shifted = {rem_q[31:0], num_q[31]};
	assign trial = shifted - {1'b0, den_q};
	assign remainder = rem_q[31:0];

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[30:0], 1'b0};
			rem_q <= trial[32] ? shifted : trial;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
endmodule

[hdl/mtrd_back.sv]
`timescale 1ns / 1ps
module mtrd_back
	import mtrd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  cmd_t        cmd,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] draw_value
);
	// Word table, one write port, one read port with registered data.
	logic [31:0] mem [TblLen];
	logic [31:0] rd_q;
	logic [IdxW-1:0] raddr;
	logic        we;
	logic [IdxW-1:0] waddr;
	logic [31:0] wdata;

	state_t      state_q;
	state_t      state_d;
	logic [IdxW-1:0] ridx_q;
	logic [IdxW-1:0] ridx_rd;
	logic [IdxW-1:0] ptr_q;
	logic [1:0]  phase_q;
	logic [31:0] wi_q;
	logic [31:0] wn_q;
	logic [31:0] seedw_q;
	logic [31:0] range_q;
	logic [31:0] word_q;
	logic        div_start;
	logic        div_done;
	logic [31:0] div_rem;
	logic [IdxW-1:0] nxt;
	logic [IdxW-1:0] far;
	logic        last;

	assign last = (ptr_q == IdxW'(TblLen - 1));
	assign nxt = last ? '0 : ptr_q + 1'b1;
	assign far = (ptr_q < IdxW'(TblLen - TblOfs)) ? ptr_q + IdxW'(TblOfs)
		: ptr_q - IdxW'(TblLen - TblOfs);
	// An exhausted index reads word 0, which the twist needs first.
	assign ridx_rd = (ridx_q == IdxW'(TblLen)) ? '0 : ridx_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	// Read address and write selection per state and phase.
	always_comb begin
		raddr = ptr_q;
		we = 1'b0;
		waddr = ptr_q;
		wdata = '0;
		unique case (state_q)
			ST_CLEAR: begin
				we = 1'b1;
			end
			ST_SEED: begin
				we = 1'b1;
				wdata = seedw_q;
			end
			ST_TWIST: begin
				// Phase 0 reads next, 1 reads far, 2 writes.
				unique case (phase_q)
					2'd0: raddr = nxt;
					2'd1: raddr = far;
					default: begin
						raddr = far;
						we = 1'b1;
						wdata = mix_word(wi_q, wn_q, rd_q);
					end
				endcase
			end
			ST_READ: raddr = ridx_rd;
			default: raddr = ridx_rd;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					if (cmd.kind == REQ_SEED) begin
						state_d = ST_SEED;
					end else if (ridx_q == IdxW'(TblLen)) begin
						state_d = ST_TWIST;
					end else begin
						state_d = ST_READ;
					end
				end
			end
			ST_CLEAR: if (last) state_d = ST_IDLE;
			ST_SEED: if (last) state_d = ST_IDLE;
			ST_TWIST: if (last && phase_q == 2'd2) state_d = ST_READ;
			ST_READ: if (phase_q == 2'd1) state_d = ST_DIV;
			ST_DIV: if (div_done) state_d = ST_OUT;
			ST_OUT: if (out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_ready = (state_q == ST_IDLE);
		out_valid = (state_q == ST_OUT);
		div_start = (state_q == ST_READ) && (phase_q == 2'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			ridx_q <= IdxW'(1);
			ptr_q <= '0;
			phase_q <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					ptr_q <= '0;
					phase_q <= '0;
					if (cmd_valid && cmd.kind == REQ_DRAW && ridx_q == IdxW'(TblLen)) begin
						ridx_q <= '0;
					end
				end
				ST_CLEAR, ST_SEED: begin
					ptr_q <= nxt;
					if (state_q == ST_SEED && last) begin
						ridx_q <= IdxW'(1);
					end
				end
				ST_TWIST: begin
					if (phase_q == 2'd2) begin
						phase_q <= '0;
						ptr_q <= nxt;
					end else begin
						phase_q <= phase_q + 2'd1;
					end
				end
				ST_READ: begin
					phase_q <= phase_q + 2'd1;
					if (phase_q == 2'd1) begin
						ridx_q <= ridx_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Word pipeline for the twist and the draw.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			seedw_q <= cmd.seed;
			range_q <= cmd.range;
		end else if (state_q == ST_SEED) begin
			seedw_q <= seedw_q * SeedMul;
		end
		if (state_q == ST_TWIST) begin
			// Word 0 comes from the idle read; each later word is the previous next word.
			// The last entry reads the new word 0 as its next word.
			if (phase_q == 2'd0 && ptr_q == '0) begin
				wi_q <= rd_q;
			end
			if (phase_q == 2'd1) begin
				wn_q <= rd_q;
			end
			if (phase_q == 2'd2) begin
				wi_q <= wn_q;
			end
		end
		if (state_q == ST_READ && phase_q == 2'd1) begin
			word_q <= temper(rd_q);
		end
		if (div_done) begin
			draw_value <= (range_q == '0) ? '0 : (range_q == '1) ? word_q : div_rem;
		end
	end

	mtrd_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (temper(rd_q)),
		.divisor   (range_q),
		.done      (div_done),
		.remainder (div_rem)
	);
endmodule

[hdl/mersenne_twister_ranged_draw.sv]
`timescale 1ns / 1ps
// Ranged random draw from a 32-bit Mersenne Twister with linear seeding.
// Input channel (in_valid/in_ready): req_type 0 draws a number reduced by
// range_limit; req_type 1 reseeds the 624-word table from seed_value.
// Output channel (out_valid/out_ready): one draw_value per draw, none
// per reseed. A front queue of two items takes input while the back end
// works, so input is held only once the queue is full.
// A draw reads the table word, tempers it, forms the bit-serial remainder
// and hands the result off. A reseed writes the table one word at a time.
// The draw that finds the index at 624 first regenerates the table, each
// word needing two reads and a write through the single read port of the
// table memory.
// After reset the block clears the table to zero and accepts commands
// into the queue but does not run them until done.
// When the receiver stalls, the result holds and the back end waits.
module mersenne_twister_ranged_draw
	import mtrd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [31:0] seed_value,
	input  logic [31:0] range_limit,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] draw_value
);
	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;

	mtrd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.seed_value  (seed_value),
		.range_limit (range_limit),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.cmd         (cmd)
	);

	mtrd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.draw_value (draw_value)
	);

	// A held result does not change while the receiver stalls.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(draw_value))
		else $error("result changed under stall");

	// The back end takes no command while a result waits.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && cmd_ready))
		else $error("command taken while result pending");
endmodule
